// ----- rtl/core/positional_array_list_defines.svh -----
// ---------------------------------------------------------------------------
// Positional array list: assertion macros
// Shared property forms used by the list's RTL. The enclosing module must
// provide clk and rst.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define PAL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/pal_pkg.sv -----
// ---------------------------------------------------------------------------
// pal_pkg
// Types, widths and codes shared by the positional array list modules.
// ---------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

  localparam int FUNC_W        = 2;
  localparam int POS_W         = 6;
  localparam int VALUE_W       = 32;
  localparam int STATUS_W      = 3;
  localparam int INDEX_W       = 6;
  localparam int COUNT_W       = 7;
  localparam int DEPTH_DEFAULT = 64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT  = 2'd0,
    FUNC_DELETE  = 2'd1,
    FUNC_DISPLAY = 2'd2,
    FUNC_SEARCH  = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_INS,
    S_INS_WR,
    S_DEL,
    S_DEL_WR,
    S_SRC,
    S_SRC_CMP,
    S_DSP,
    S_DSP_OUT,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    start;
    logic    rd_en;
    logic    wr_en;
    logic    wr_value;
    logic    ptr_inc;
    logic    ptr_dec;
    logic    used_inc;
    logic    used_dec;
    logic    set_resp;
    status_t resp_code;
    logic    resp_hit;
    logic    out_resp;
    logic    out_elem;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_t func;
    logic  full;
    logic  empty;
    logic  pos_bad;
    logic  at_pos;
    logic  at_tail;
    logic  at_end;
    logic  match;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/pal_ctrl.sv -----
// ---------------------------------------------------------------------------
// pal_ctrl
// Sequencer for the positional array list: decodes each request and steps
// the datapath through the shift, scan or display loop.
// ---------------------------------------------------------------------------
`default_nettype none

module pal_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  pal_pkg::sts_t sts,
  output pal_pkg::cmd_t cmd
);
  import pal_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.resp_code = ST_OK;
    in_ready      = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.func)
          FUNC_INSERT: begin
            if (sts.full) begin
              cmd.set_resp  = 1'b1;
              cmd.resp_code = ST_FULL;
              state_next    = S_RESP;
            end else if (sts.pos_bad) begin
              cmd.set_resp  = 1'b1;
              cmd.resp_code = ST_BADPOS;
              state_next    = S_RESP;
            end else begin
              state_next = S_INS;
            end
          end
          FUNC_DELETE: begin
            if (sts.empty) begin
              cmd.set_resp  = 1'b1;
              cmd.resp_code = ST_EMPTY;
              state_next    = S_RESP;
            end else if (sts.pos_bad) begin
              cmd.set_resp  = 1'b1;
              cmd.resp_code = ST_BADPOS;
              state_next    = S_RESP;
            end else begin
              state_next = S_DEL;
            end
          end
          FUNC_DISPLAY: begin
            if (sts.empty) begin
              cmd.set_resp  = 1'b1;
              cmd.resp_code = ST_EMPTY;
              state_next    = S_RESP;
            end else begin
              state_next = S_DSP;
            end
          end
          default: begin
            if (sts.empty) begin
              cmd.set_resp  = 1'b1;
              cmd.resp_code = ST_EMPTY;
              state_next    = S_RESP;
            end else begin
              state_next = S_SRC;
            end
          end
        endcase
      end
      // Insert walks down from the tail, moving each entry up by one.
      S_INS: begin
        if (sts.at_pos) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_value  = 1'b1;
          cmd.used_inc  = 1'b1;
          cmd.set_resp  = 1'b1;
          cmd.resp_code = ST_OK;
          state_next    = S_RESP;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.ptr_dec = 1'b1;
        state_next  = S_INS;
      end
      // Delete walks up from the position, moving each entry down by one.
      S_DEL: begin
        if (sts.at_tail) begin
          cmd.used_dec  = 1'b1;
          cmd.set_resp  = 1'b1;
          cmd.resp_code = ST_OK;
          state_next    = S_RESP;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.ptr_inc = 1'b1;
        state_next  = S_DEL;
      end
      S_SRC: begin
        if (sts.at_end) begin
          cmd.set_resp  = 1'b1;
          cmd.resp_code = ST_NOTFOUND;
          state_next    = S_RESP;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_SRC_CMP;
        end
      end
      S_SRC_CMP: begin
        if (sts.match) begin
          cmd.set_resp  = 1'b1;
          cmd.resp_code = ST_OK;
          cmd.resp_hit  = 1'b1;
          state_next    = S_RESP;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next  = S_SRC;
        end
      end
      S_DSP: begin
        cmd.rd_en  = 1'b1;
        state_next = S_DSP_OUT;
      end
      S_DSP_OUT: begin
        if (sts.out_free) begin
          cmd.out_elem = 1'b1;
          if (sts.at_tail) begin
            state_next = S_IDLE;
          end else begin
            cmd.ptr_inc = 1'b1;
            state_next  = S_DSP;
          end
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_resp = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/pal_dp.sv -----
// ---------------------------------------------------------------------------
// pal_dp
// Datapath of the positional array list: entry memory, fill count, walking
// pointer, latched request and the result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "positional_array_list_defines.svh"

module pal_dp #(
  parameter int DEPTH = pal_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pal_pkg::cmd_t                     cmd,
  output pal_pkg::sts_t                     sts,
  input  logic [pal_pkg::FUNC_W-1:0]        func,
  input  logic [pal_pkg::POS_W-1:0]         position,
  input  logic signed [pal_pkg::VALUE_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pal_pkg::STATUS_W-1:0]      status,
  output logic [pal_pkg::INDEX_W-1:0]       index,
  output logic signed [pal_pkg::VALUE_W-1:0] element,
  output logic [pal_pkg::COUNT_W-1:0]       count,
  output logic                              last
);
  import pal_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata;

  func_t              req_func;
  logic [POS_W-1:0]   req_pos;
  logic [VALUE_W-1:0] req_value;

  logic [CW-1:0]      used;
  logic [CW-1:0]      ptr;
  logic [CW-1:0]      ptr_next;
  logic [CW-1:0]      ptr_up;
  logic [CW-1:0]      ptr_down;
  logic [CW-1:0]      raddr;

  status_t            resp_status;
  logic [INDEX_W-1:0] resp_index;

  logic [COUNT_W-1:0] pos_ext;
  logic [COUNT_W-1:0] used_ext;
  logic               out_free;

  assign ptr_up   = ptr + 1'b1;
  assign ptr_down = ptr - 1'b1;
  assign pos_ext  = COUNT_W'(req_pos);
  assign used_ext = COUNT_W'(used);
  assign out_free = !out_valid || out_ready;

  // Insert reads the entry below the pointer, delete the one above it.
  always_comb begin
    case (req_func)
      FUNC_INSERT: raddr = ptr_down;
      FUNC_DELETE: raddr = ptr_up;
      default:     raddr = ptr;
    endcase
  end

  always_comb begin
    case (func_t'(func))
      FUNC_INSERT: ptr_next = used;
      FUNC_DELETE: ptr_next = CW'(position);
      default:     ptr_next = '0;
    endcase
  end

  always_comb begin
    sts.func     = req_func;
    sts.full     = (used == CW'(DEPTH));
    sts.empty    = (used == '0);
    sts.pos_bad  = (req_func == FUNC_INSERT) ? (pos_ext > used_ext) : (pos_ext >= used_ext);
    sts.at_pos   = (ptr == CW'(req_pos));
    sts.at_tail  = (ptr_up == used);
    sts.at_end   = (ptr == used);
    sts.match    = (rdata == req_value);
    sts.out_free = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[ptr[IW-1:0]] <= cmd.wr_value ? req_value : rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[raddr[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_func  <= func_t'(func);
      req_pos   <= position;
      req_value <= value;
      ptr       <= ptr_next;
    end else if (cmd.ptr_inc) begin
      ptr <= ptr_up;
    end else if (cmd.ptr_dec) begin
      ptr <= ptr_down;
    end
    if (cmd.set_resp) begin
      resp_status <= cmd.resp_code;
      resp_index  <= cmd.resp_hit ? INDEX_W'(ptr) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.used_inc) begin
      used <= used + 1'b1;
    end else if (cmd.used_dec) begin
      used <= used - 1'b1;
    end
  end

  // Result register: a new result may be loaded in the cycle the old one leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_resp || cmd.out_elem) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_resp) begin
      status  <= resp_status;
      index   <= resp_index;
      element <= '0;
      count   <= used_ext;
      last    <= 1'b1;
    end else if (cmd.out_elem) begin
      status  <= ST_OK;
      index   <= INDEX_W'(ptr);
      element <= rdata;
      count   <= used_ext;
      last    <= sts.at_tail;
    end
  end

  `PAL_ASSERT_SAME(a_used_bound, 1'b1, used <= CW'(DEPTH), "fill count above depth")
  `PAL_ASSERT_SAME(a_wr_in_range, cmd.wr_en, ptr < CW'(DEPTH), "write beyond the memory")
  `PAL_ASSERT_SAME(a_load_free, cmd.out_resp || cmd.out_elem, out_free, "result overwritten")
  `PAL_ASSERT_NEXT(a_used_grows, cmd.used_inc, used == $past(used) + 1'b1, "insert lost count")

endmodule

`default_nettype wire

// ----- rtl/core/positional_array_list.sv -----
// ---------------------------------------------------------------------------
// positional_array_list
// Ordered list of up to DEPTH signed 32-bit values with insert, delete,
// search and display requests.
// ---------------------------------------------------------------------------
// Usage: the request channel (in_valid/in_ready) carries func, position and
// value; the result channel (out_valid/out_ready) carries status, index,
// element, count and last. Insert, delete and search give one result each;
// display gives one result per stored entry with last on the final one, or
// a single empty status when nothing is stored.
// A request is taken only while the sequencer is idle. Entries live in a
// single-port-per-direction memory, so every moved or inspected entry takes
// a read step, then a write or compare step. Insert moves each entry from
// position to the tail, delete each entry above position, search inspects
// entries until a match, and display outputs every entry. Rejected requests
// go from decode straight to the response step. A result waits in an output
// register; while the receiver stalls, display and the final response step
// hold, and a new request is taken as soon as the last result is loaded.
// Reset clears the fill count and empties the list; memory contents are
// not cleared, and only entries below the count are ever read.
// ---------------------------------------------------------------------------
`default_nettype none

module positional_array_list #(
  parameter int DEPTH = pal_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pal_pkg::FUNC_W-1:0]         func,
  input  logic [pal_pkg::POS_W-1:0]          position,
  input  logic signed [pal_pkg::VALUE_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pal_pkg::STATUS_W-1:0]       status,
  output logic [pal_pkg::INDEX_W-1:0]        index,
  output logic signed [pal_pkg::VALUE_W-1:0] element,
  output logic [pal_pkg::COUNT_W-1:0]        count,
  output logic                               last
);
  import pal_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pal_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .func      (func),
    .position  (position),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .index     (index),
    .element   (element),
    .count     (count),
    .last      (last)
  );

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// Positional array list testbench
// Drives insert, delete, display and search requests into the list through
// its request channel, keeps its own copy of the list to predict every
// result, and checks each result field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pal_pkg::*;

  localparam int LIST_DEPTH  = DEPTH_DEFAULT;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 150;

  typedef struct packed {
    status_t                    status;
    logic [INDEX_W-1:0]         index;
    logic signed [VALUE_W-1:0]  element;
    logic [COUNT_W-1:0]         count;
    logic                       last;
  } list_result_t;

  class list_scoreboard;
    logic signed [VALUE_W-1:0] slots [LIST_DEPTH];
    int unsigned               used;
    list_result_t              awaited [$];
    int unsigned               errors;

    function string fmt(list_result_t r);
      return $sformatf("status=%0d index=%0d element=%0d count=%0d last=%0b",
                       r.status, r.index, r.element, r.count, r.last);
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function void push(status_t st, int unsigned at, logic signed [VALUE_W-1:0] elem,
                       bit fin);
      list_result_t r;
      r.status  = st;
      r.index   = at[INDEX_W-1:0];
      r.element = elem;
      r.count   = used[COUNT_W-1:0];
      r.last    = fin;
      awaited.push_back(r);
    endfunction

    // Applies one accepted request to the list copy and queues its results.
    function void note_request(func_t f, logic [POS_W-1:0] p,
                               logic signed [VALUE_W-1:0] v);
      int found;
      found = -1;
      case (f)
        FUNC_INSERT: begin
          if (used >= LIST_DEPTH) begin
            push(ST_FULL, 0, 0, 1'b1);
          end else if (p > used) begin
            push(ST_BADPOS, 0, 0, 1'b1);
          end else begin
            for (int i = used; i > int'(p); i--) slots[i] = slots[i-1];
            slots[p] = v;
            used++;
            push(ST_OK, 0, 0, 1'b1);
          end
        end
        FUNC_DELETE: begin
          if (used == 0) begin
            push(ST_EMPTY, 0, 0, 1'b1);
          end else if (p >= used) begin
            push(ST_BADPOS, 0, 0, 1'b1);
          end else begin
            for (int i = p; i + 1 < int'(used); i++) slots[i] = slots[i+1];
            used--;
            push(ST_OK, 0, 0, 1'b1);
          end
        end
        FUNC_DISPLAY: begin
          if (used == 0) begin
            push(ST_EMPTY, 0, 0, 1'b1);
          end else begin
            for (int i = 0; i < int'(used); i++)
              push(ST_OK, i, slots[i], (i + 1 == int'(used)));
          end
        end
        FUNC_SEARCH: begin
          if (used == 0) begin
            push(ST_EMPTY, 0, 0, 1'b1);
          end else begin
            for (int i = 0; i < int'(used); i++)
              if (found < 0 && slots[i] == v) found = i;
            if (found >= 0) push(ST_OK, found, 0, 1'b1);
            else push(ST_NOTFOUND, 0, 0, 1'b1);
          end
        end
      endcase
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (awaited.size() == 0) begin
        flag({"result with nothing outstanding: got ", fmt(got)});
      end else begin
        want = awaited.pop_front();
        if (got.status !== want.status || got.index !== want.index ||
            got.element !== want.element || got.count !== want.count ||
            got.last !== want.last)
          flag({"expected ", fmt(want), " got ", fmt(got)});
      end
    endfunction

    function void close();
      while (awaited.size() != 0)
        flag({"never received: expected ", fmt(awaited.pop_front())});
    endfunction
  endclass

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic [FUNC_W-1:0]         func      = '0;
  logic [POS_W-1:0]          position  = '0;
  logic signed [VALUE_W-1:0] value     = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [STATUS_W-1:0]       status;
  logic [INDEX_W-1:0]        index;
  logic signed [VALUE_W-1:0] element;
  logic [COUNT_W-1:0]        count;
  logic                      last;

  list_scoreboard sb = new();
  int             send_idle = 0;
  int             recv_idle = 0;
  int             phase     = 0;
  int unsigned    sent      = 0;

  positional_array_list #(.DEPTH(LIST_DEPTH)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .position  (position),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .index     (index),
    .element   (element),
    .count     (count),
    .last      (last)
  );

  always #2 clk = ~clk;

  // Mixes extreme and repeated values with fully random ones so that
  // duplicate entries occur and searches must find the first of them.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return -1;
      3: return 42;
      default: return $urandom;
    endcase
  endfunction

  task automatic offer(func_t f, logic [POS_W-1:0] p, logic signed [VALUE_W-1:0] v);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    position <= p;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(f, p, v);
    sent++;
  endtask

  // Result side: checks on every handshake and, once in the last phase,
  // holds off for a long stretch so that the list backs up onto its input.
  initial begin
    list_result_t got;
    int unsigned  hold_left;
    bit           held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.status  = status_t'(status);
        got.index   = index;
        got.element = element;
        got.count   = count;
        got.last    = last;
        sb.check_result(got);
      end
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (phase == 2 && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned        phase_end [3];
    int unsigned        pick;
    func_t              f;
    logic [POS_W-1:0]   p;
    logic signed [31:0] v;
    phase_end = '{100, 230, 320};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 3; ph++) begin
      phase     = ph;
      send_idle = (ph == 0) ? 34 : (ph == 1) ? 61 : 0;
      recv_idle = (ph == 0) ? 61 : (ph == 1) ? 34 : 0;

      if (ph == 0) begin
        // Empty list cases, then edges of position and value.
        offer(FUNC_DISPLAY, 6'd0, 0);
        offer(FUNC_SEARCH, 6'd63, 0);
        offer(FUNC_DELETE, 6'd0, 0);
        offer(FUNC_INSERT, 6'd1, 5);
        offer(FUNC_INSERT, 6'd0, 32'sh7FFF_FFFF);
        offer(FUNC_INSERT, 6'd0, 32'sh8000_0000);
        offer(FUNC_INSERT, 6'd2, -1);
        offer(FUNC_INSERT, 6'd1, 0);
        offer(FUNC_INSERT, 6'd63, 7);
        offer(FUNC_INSERT, 6'd4, 32'sh7FFF_FFFF);
        offer(FUNC_DISPLAY, 6'd63, -1);
        offer(FUNC_SEARCH, 6'd0, 32'sh7FFF_FFFF);
        offer(FUNC_SEARCH, 6'd0, 12345);
        offer(FUNC_DELETE, 6'd63, 0);
        offer(FUNC_DELETE, 6'd5, 0);
        offer(FUNC_DELETE, 6'd4, 0);
        offer(FUNC_DELETE, 6'd0, -1);
        offer(FUNC_DISPLAY, 6'd0, 0);
        offer(FUNC_SEARCH, 6'd21, 32'sh8000_0000);
      end

      if (ph == 1) begin
        // Fill to capacity, knock on a full list, dump it whole, then drain to eight entries.
        while (sb.used < LIST_DEPTH)
          offer(FUNC_INSERT, POS_W'($urandom_range(0, sb.used)), pick_value());
        offer(FUNC_INSERT, POS_W'($urandom_range(0, 63)), pick_value());
        offer(FUNC_INSERT, 6'd63, pick_value());
        offer(FUNC_DISPLAY, POS_W'($urandom_range(0, 63)), $urandom);
        offer(FUNC_SEARCH, 6'd0, sb.slots[$urandom_range(0, LIST_DEPTH - 1)]);
        offer(FUNC_DELETE, 6'd63, $urandom);
        while (sb.used > 8)
          offer(FUNC_DELETE, POS_W'($urandom_range(0, sb.used - 1)), $urandom);
      end

      while (sent < phase_end[ph]) begin
        pick = $urandom_range(0, 99);
        p    = POS_W'($urandom_range(0, 63));
        v    = pick_value();
        if (pick < 40) begin
          f = FUNC_INSERT;
          if ($urandom_range(0, 99) < 85)
            p = POS_W'($urandom_range(0, (sb.used > 63) ? 63 : sb.used));
        end else if (pick < 65) begin
          f = FUNC_DELETE;
          if (sb.used != 0 && $urandom_range(0, 99) < 85)
            p = POS_W'($urandom_range(0, sb.used - 1));
        end else if (pick < 88) begin
          f = FUNC_SEARCH;
          if (sb.used != 0 && $urandom_range(0, 99) < 60)
            v = sb.slots[$urandom_range(0, sb.used - 1)];
        end else begin
          f = FUNC_DISPLAY;
        end
        offer(f, p, v);
      end
    end
    in_valid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    sb.close();

    if (sb.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
